### hw/rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants for the sorted record table.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int NAME_BYTES  = 20;
  localparam int DUMP_MAX    = 16;

  // bytes of each name word that are kept
  localparam int NB_A = (NAME_BYTES >= 8) ? 8 : NAME_BYTES;
  localparam int NB_B = (NAME_BYTES >= 16) ? 8 : ((NAME_BYTES > 8) ? NAME_BYTES - 8 : 0);
  localparam int NB_C = (NAME_BYTES > 16) ? NAME_BYTES - 16 : 0;

  localparam logic [63:0] MASK_A = (NB_A == 8) ? {64{1'b1}} :
                                   ((64'd1 << (8 * NB_A)) - 64'd1);
  localparam logic [63:0] MASK_B = (NB_B == 8) ? {64{1'b1}} :
                                   ((64'd1 << (8 * NB_B)) - 64'd1);
  localparam logic [31:0] MASK_C = (NB_C == 4) ? {32{1'b1}} :
                                   ((32'd1 << (8 * NB_C)) - 32'd1);

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_SORT   = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_DUMP   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_ENTRY    = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] rec_key;
    logic        rec_sex;
    logic [63:0] name_first8;
    logic [63:0] name_next8;
    logic [31:0] name_last4;
    logic [13:0] rec_year;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_key;
    logic        out_sex;
    logic [63:0] out_name_first8;
    logic [63:0] out_name_next8;
    logic [31:0] out_name_last4;
    logic [13:0] out_year;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic [15:0] key;
    logic        sex;
    logic [63:0] na;
    logic [63:0] nb;
    logic [31:0] nc;
    logic [13:0] year;
  } rec_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPEND,
    OP_RD_I,
    OP_LD_CUR,
    OP_RD_J,
    OP_SWAP_J,
    OP_WR_I,
    OP_RD_P,
    OP_INS_TAIL,
    OP_INS_STEP,
    OP_DEL_STEP,
    OP_DEC,
    OP_EMIT_REC,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRT_RDI,
    S_SRT_LDI,
    S_SRT_RDJ,
    S_SRT_CMP,
    S_SRT_WBI,
    S_INS_RD,
    S_INS_EV,
    S_DEL_RD,
    S_DEL_EV,
    S_DMP_RD,
    S_DMP_EM,
    S_REPLY
  } state_e;

  typedef struct packed {
    dp_op_e  op;
    status_e st;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic full;
    logic empty;
    logic p_end;
    logic found;
    logic dmp_last;
    logic j_end;
    logic j_last;
    logic i_last;
  } sts_t;

endpackage

### hw/rtl/srt_ram.sv
// ----------------------------------------------------------------------------
// srt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/srt_ctrl.sv
// ----------------------------------------------------------------------------
// srt_ctrl
// Request sequencer: walks each operation and issues datapath commands.
// ----------------------------------------------------------------------------
module srt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  srt_pkg::sts_t sts_i,
  output srt_pkg::cmd_t cmd_o
);

  srt_pkg::state_e  state_q, state_d;
  srt_pkg::status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srt_pkg::S_IDLE;
      st_q    <= srt_pkg::ST_DONE;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    case (state_q)
      srt_pkg::S_IDLE: begin
        if (start_i) state_d = srt_pkg::S_DECODE;
      end
      srt_pkg::S_DECODE: begin
        state_d = srt_pkg::S_REPLY;
        st_d    = srt_pkg::ST_DONE;
        case (sts_i.req)
          srt_pkg::REQ_APPEND: begin
            if (sts_i.full) st_d = srt_pkg::ST_FULL;
          end
          srt_pkg::REQ_SORT: begin
            if (sts_i.empty) st_d = srt_pkg::ST_EMPTY;
            else state_d = srt_pkg::S_SRT_RDI;
          end
          srt_pkg::REQ_INSERT: begin
            if (sts_i.full) st_d = srt_pkg::ST_FULL;
            else state_d = srt_pkg::S_INS_RD;
          end
          srt_pkg::REQ_DELETE: begin
            if (sts_i.empty) st_d = srt_pkg::ST_EMPTY;
            else state_d = srt_pkg::S_DEL_RD;
          end
          srt_pkg::REQ_DUMP: begin
            if (sts_i.empty) st_d = srt_pkg::ST_EMPTY;
            else state_d = srt_pkg::S_DMP_RD;
          end
          default: ;
        endcase
      end
      srt_pkg::S_SRT_RDI: state_d = srt_pkg::S_SRT_LDI;
      srt_pkg::S_SRT_LDI: begin
        state_d = sts_i.j_end ? srt_pkg::S_SRT_WBI : srt_pkg::S_SRT_RDJ;
      end
      srt_pkg::S_SRT_RDJ: state_d = srt_pkg::S_SRT_CMP;
      srt_pkg::S_SRT_CMP: begin
        state_d = sts_i.j_last ? srt_pkg::S_SRT_WBI : srt_pkg::S_SRT_RDJ;
      end
      srt_pkg::S_SRT_WBI: begin
        if (sts_i.i_last) begin
          state_d = srt_pkg::S_REPLY;
          st_d    = srt_pkg::ST_DONE;
        end else begin
          state_d = srt_pkg::S_SRT_RDI;
        end
      end
      srt_pkg::S_INS_RD: begin
        if (sts_i.p_end) begin
          state_d = srt_pkg::S_REPLY;
          st_d    = srt_pkg::ST_DONE;
        end else begin
          state_d = srt_pkg::S_INS_EV;
        end
      end
      srt_pkg::S_INS_EV: state_d = srt_pkg::S_INS_RD;
      srt_pkg::S_DEL_RD: begin
        if (sts_i.p_end) begin
          state_d = srt_pkg::S_REPLY;
          st_d    = sts_i.found ? srt_pkg::ST_DONE : srt_pkg::ST_NOTFOUND;
        end else begin
          state_d = srt_pkg::S_DEL_EV;
        end
      end
      srt_pkg::S_DEL_EV: state_d = srt_pkg::S_DEL_RD;
      srt_pkg::S_DMP_RD: state_d = srt_pkg::S_DMP_EM;
      srt_pkg::S_DMP_EM: begin
        state_d = sts_i.dmp_last ? srt_pkg::S_IDLE : srt_pkg::S_DMP_RD;
      end
      srt_pkg::S_REPLY: state_d = srt_pkg::S_IDLE;
      default: state_d = srt_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o.op = srt_pkg::OP_NONE;
    cmd_o.st = st_q;
    busy_o   = 1'b1;
    case (state_q)
      srt_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) cmd_o.op = srt_pkg::OP_LOAD;
      end
      srt_pkg::S_DECODE: begin
        if (sts_i.req == srt_pkg::REQ_APPEND && !sts_i.full) cmd_o.op = srt_pkg::OP_APPEND;
      end
      srt_pkg::S_SRT_RDI: cmd_o.op = srt_pkg::OP_RD_I;
      srt_pkg::S_SRT_LDI: cmd_o.op = srt_pkg::OP_LD_CUR;
      srt_pkg::S_SRT_RDJ: cmd_o.op = srt_pkg::OP_RD_J;
      srt_pkg::S_SRT_CMP: cmd_o.op = srt_pkg::OP_SWAP_J;
      srt_pkg::S_SRT_WBI: cmd_o.op = srt_pkg::OP_WR_I;
      srt_pkg::S_INS_RD: begin
        cmd_o.op = sts_i.p_end ? srt_pkg::OP_INS_TAIL : srt_pkg::OP_RD_P;
      end
      srt_pkg::S_INS_EV: cmd_o.op = srt_pkg::OP_INS_STEP;
      srt_pkg::S_DEL_RD: begin
        if (!sts_i.p_end) cmd_o.op = srt_pkg::OP_RD_P;
        else if (sts_i.found) cmd_o.op = srt_pkg::OP_DEC;
      end
      srt_pkg::S_DEL_EV: cmd_o.op = srt_pkg::OP_DEL_STEP;
      srt_pkg::S_DMP_RD: cmd_o.op = srt_pkg::OP_RD_P;
      srt_pkg::S_DMP_EM: cmd_o.op = srt_pkg::OP_EMIT_REC;
      srt_pkg::S_REPLY:  cmd_o.op = srt_pkg::OP_EMIT;
      default: ;
    endcase
  end

endmodule

### hw/rtl/srt_dpath.sv
// ----------------------------------------------------------------------------
// srt_dpath
// Table storage, walk indices, entry count and result register.
// ----------------------------------------------------------------------------
module srt_dpath #(
  parameter int TABLE_DEPTH = srt_pkg::TABLE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  srt_pkg::req_t req_i,
  input  srt_pkg::cmd_t cmd_i,
  output srt_pkg::sts_t sts_o,
  output logic          res_valid_o,
  output srt_pkg::res_t res_o
);

  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int RecW  = $bits(srt_pkg::rec_t);

  logic [CntW-1:0] count_q, p_q, i_q, j_q, lim;
  logic            found_q, ins_q;
  srt_pkg::req_e   req_q;
  srt_pkg::rec_t   nr_q, hold_q, rdat;
  logic [RecW-1:0] rdata;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  srt_pkg::rec_t    wdata;

  srt_ram #(
    .WIDTH (RecW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rdat = srt_pkg::rec_t'(rdata);
  assign lim  = (int'(count_q) < srt_pkg::DUMP_MAX) ? count_q : CntW'(srt_pkg::DUMP_MAX);

  assign sts_o.req      = req_q;
  assign sts_o.full     = (int'(count_q) == TABLE_DEPTH);
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.p_end    = (p_q == count_q);
  assign sts_o.found    = found_q;
  assign sts_o.dmp_last = ((p_q + CntW'(1)) == lim);
  assign sts_o.j_end    = (j_q >= count_q);
  assign sts_o.j_last   = ((j_q + CntW'(1)) >= count_q);
  assign sts_o.i_last   = ((i_q + CntW'(1)) >= count_q);

  // memory port steering
  always_comb begin
    we    = 1'b0;
    waddr = p_q[AddrW-1:0];
    wdata = hold_q;
    raddr = p_q[AddrW-1:0];
    case (cmd_i.op)
      srt_pkg::OP_APPEND: begin
        we    = 1'b1;
        waddr = count_q[AddrW-1:0];
        wdata = nr_q;
      end
      srt_pkg::OP_RD_I: raddr = i_q[AddrW-1:0];
      srt_pkg::OP_RD_J: raddr = j_q[AddrW-1:0];
      srt_pkg::OP_SWAP_J: begin
        we    = (hold_q.key > rdat.key);
        waddr = j_q[AddrW-1:0];
      end
      srt_pkg::OP_WR_I: begin
        we    = 1'b1;
        waddr = i_q[AddrW-1:0];
      end
      srt_pkg::OP_INS_TAIL: begin
        we    = 1'b1;
        wdata = ins_q ? hold_q : nr_q;
      end
      srt_pkg::OP_INS_STEP: begin
        we    = ins_q || (rdat.key >= nr_q.key);
        wdata = ins_q ? hold_q : nr_q;
      end
      srt_pkg::OP_DEL_STEP: begin
        we    = found_q;
        waddr = AddrW'(p_q - CntW'(1));
        wdata = rdat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      p_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      found_q     <= 1'b0;
      ins_q       <= 1'b0;
      req_q       <= srt_pkg::REQ_APPEND;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      case (cmd_i.op)
        srt_pkg::OP_LOAD: begin
          req_q   <= srt_pkg::req_e'(req_i.req_type);
          p_q     <= '0;
          i_q     <= '0;
          found_q <= 1'b0;
          ins_q   <= 1'b0;
        end
        srt_pkg::OP_APPEND:   count_q <= count_q + CntW'(1);
        srt_pkg::OP_RD_I:     j_q <= i_q + CntW'(1);
        srt_pkg::OP_SWAP_J:   j_q <= j_q + CntW'(1);
        srt_pkg::OP_WR_I:     i_q <= i_q + CntW'(1);
        srt_pkg::OP_INS_TAIL: count_q <= count_q + CntW'(1);
        srt_pkg::OP_INS_STEP: begin
          if (rdat.key >= nr_q.key) ins_q <= 1'b1;
          p_q <= p_q + CntW'(1);
        end
        srt_pkg::OP_DEL_STEP: begin
          if (rdat.key == nr_q.key) found_q <= 1'b1;
          p_q <= p_q + CntW'(1);
        end
        srt_pkg::OP_DEC:      count_q <= count_q - CntW'(1);
        srt_pkg::OP_EMIT_REC: begin
          p_q         <= p_q + CntW'(1);
          res_valid_o <= 1'b1;
        end
        srt_pkg::OP_EMIT:     res_valid_o <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      srt_pkg::OP_LOAD: begin
        nr_q.key  <= req_i.rec_key;
        nr_q.sex  <= req_i.rec_sex;
        nr_q.na   <= req_i.name_first8 & srt_pkg::MASK_A;
        nr_q.nb   <= req_i.name_next8 & srt_pkg::MASK_B;
        nr_q.nc   <= req_i.name_last4 & srt_pkg::MASK_C;
        nr_q.year <= req_i.rec_year;
      end
      srt_pkg::OP_LD_CUR: hold_q <= rdat;
      srt_pkg::OP_SWAP_J: begin
        if (hold_q.key > rdat.key) hold_q <= rdat;
      end
      srt_pkg::OP_INS_STEP: begin
        if (ins_q || (rdat.key >= nr_q.key)) hold_q <= rdat;
      end
      srt_pkg::OP_EMIT_REC: begin
        res_o.status          <= srt_pkg::ST_ENTRY;
        res_o.out_key         <= rdat.key;
        res_o.out_sex         <= rdat.sex;
        res_o.out_name_first8 <= rdat.na;
        res_o.out_name_next8  <= rdat.nb;
        res_o.out_name_last4  <= rdat.nc;
        res_o.out_year        <= rdat.year;
        res_o.last_result     <= sts_o.dmp_last;
      end
      srt_pkg::OP_EMIT: begin
        // status on top, record fields zero, last flag set
        res_o <= srt_pkg::res_t'({cmd_i.st, {($bits(srt_pkg::res_t) - 4){1'b0}}, 1'b1});
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/sorted_record_table.sv
// ----------------------------------------------------------------------------
// sorted_record_table
// Bounded ordered table of records: append, sort, insert, delete, dump.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_i and raise start_i; the transfer happens at
//   the clock edge where start_i is high and busy_o is low. busy_o stays high
//   until the request's last result has been issued.
//   Result channel: each result is on res_o for one cycle with res_valid_o
//   high. The receiver cannot stall; a result is gone after that cycle.
//   res_o.last_result marks the final result of a request.
// Operations (n = entries held), one table RAM, each entry read then acted on:
//   append, unknown codes, or any rejected/empty request: one status result.
//   insert, delete: walk all n entries, then one status result.
//   dump: one result per entry up to DUMP_MAX; no new request until the last.
//   sort: a compare loop reads each later entry against the held entry,
//   then one status result.
// Reset: clears the entry count and the sequencer; table contents are left
//   as they are and are never read before being written.
// ----------------------------------------------------------------------------
module sorted_record_table #(
  parameter int TABLE_DEPTH = srt_pkg::TABLE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  srt_pkg::req_t req_i,
  output logic          res_valid_o,
  output srt_pkg::res_t res_o
);

  srt_pkg::cmd_t cmd;  // sequencer -> datapath
  srt_pkg::sts_t sts;  // datapath -> sequencer

  srt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // Table lives in one RAM; walks read an entry, then act on it the next cycle.
  srt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

### hw/rtl/srt_checker.sv
// ----------------------------------------------------------------------------
// srt_checker
// Port-level checks for the sorted record table.
// ----------------------------------------------------------------------------
module srt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          res_valid_o,
  input srt_pkg::res_t res_o
);

  // a status-only result ends its request
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != srt_pkg::ST_ENTRY |-> res_o.last_result)
    else $error("status result without last flag");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != srt_pkg::ST_ENTRY |->
      res_o.out_key == '0 && res_o.out_year == '0 && res_o.out_name_first8 == '0)
    else $error("status result carries record data");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("transfer not followed by busy");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_result |=> !res_valid_o)
    else $error("result right after final result");

endmodule

bind sorted_record_table srt_checker u_srt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

### dv/sorted_record_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_record_table_tb
// Drives random and directed table requests (append, sort, insert, delete,
// dump, unknown codes) and checks every result against a behavioral copy of
// the table kept in a scoreboard class.
// ----------------------------------------------------------------------------
module sorted_record_table_tb;

  // Behavioral copy of the table plus the queue of results it predicts.
  class table_scoreboard;
    srt_pkg::rec_t rows[srt_pkg::TABLE_DEPTH];
    int            count;
    srt_pkg::res_t pending[$];
    int            errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void push_status(srt_pkg::status_e st);
      srt_pkg::res_t r;
      r = '0;
      r.status      = st;
      r.last_result = 1'b1;
      pending.push_back(r);
    endfunction

    // Note one accepted request and queue the results it will cause.
    function void note_request(srt_pkg::req_t q);
      srt_pkg::rec_t nr, t;
      srt_pkg::res_t r;
      int   i, j, m;
      nr.key  = q.rec_key;
      nr.sex  = q.rec_sex;
      nr.na   = q.name_first8 & srt_pkg::MASK_A;
      nr.nb   = q.name_next8 & srt_pkg::MASK_B;
      nr.nc   = q.name_last4 & srt_pkg::MASK_C;
      nr.year = q.rec_year;
      case (q.req_type)
        srt_pkg::REQ_APPEND: begin
          if (count >= srt_pkg::TABLE_DEPTH) begin
            push_status(srt_pkg::ST_FULL);
            return;
          end
          rows[count] = nr;
          count++;
        end
        srt_pkg::REQ_SORT: begin
          if (count == 0) begin
            push_status(srt_pkg::ST_EMPTY);
            return;
          end
          for (i = 0; i < count; i++)
            for (j = i + 1; j < count; j++)
              if (rows[i].key > rows[j].key) begin
                t = rows[i]; rows[i] = rows[j]; rows[j] = t;
              end
        end
        srt_pkg::REQ_INSERT: begin
          if (count >= srt_pkg::TABLE_DEPTH) begin
            push_status(srt_pkg::ST_FULL);
            return;
          end
          for (i = 0; i < count && rows[i].key < nr.key; i++) ;
          for (j = count; j > i; j--) rows[j] = rows[j-1];
          rows[i] = nr;
          count++;
        end
        srt_pkg::REQ_DELETE: begin
          if (count == 0) begin
            push_status(srt_pkg::ST_EMPTY);
            return;
          end
          for (i = 0; i < count && rows[i].key != nr.key; i++) ;
          if (i == count) begin
            push_status(srt_pkg::ST_NOTFOUND);
            return;
          end
          for (j = i; j + 1 < count; j++) rows[j] = rows[j+1];
          count--;
        end
        srt_pkg::REQ_DUMP: begin
          m = (count < srt_pkg::DUMP_MAX) ? count : srt_pkg::DUMP_MAX;
          if (m == 0) begin
            push_status(srt_pkg::ST_EMPTY);
            return;
          end
          for (i = 0; i < m; i++) begin
            r.status          = srt_pkg::ST_ENTRY;
            r.out_key         = rows[i].key;
            r.out_sex         = rows[i].sex;
            r.out_name_first8 = rows[i].na;
            r.out_name_next8  = rows[i].nb;
            r.out_name_last4  = rows[i].nc;
            r.out_year        = rows[i].year;
            r.last_result     = (i + 1 == m);
            pending.push_back(r);
          end
          return;
        end
        default: ;
      endcase
      push_status(srt_pkg::ST_DONE);
    endfunction

    // Compare one result with the oldest expectation.
    function void check_result(srt_pkg::res_t got);
      srt_pkg::res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result mismatch exp %h got %h", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  srt_pkg::req_t req_i = '0;
  logic busy_o, res_valid_o;
  srt_pkg::res_t res_o;

  table_scoreboard sb;
  bit calm;        // no-idle stretch
  int keyspan;     // narrows keys to force duplicates

  sorted_record_table dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .res_valid_o, .res_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Results cannot be held off: check every strobed cycle.
  always @(posedge clk_i)
    if (rst_ni && res_valid_o) sb.check_result(res_o);

  // One request transfer, with an optional random gap before it.
  task automatic send_req(srt_pkg::req_t q);
    while (!calm && $urandom_range(99) < 37) @(posedge clk_i);
    start_i <= 1'b1;
    req_i   <= q;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(q);
    start_i <= 1'b0;
    // busy_o rises after the transfer; let it settle before the next one
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic srt_pkg::req_t rand_req(logic [2:0] op);
    srt_pkg::req_t q;
    q.req_type    = op;
    q.rec_key     = (keyspan == 0) ? 16'($urandom) : 16'($urandom_range(keyspan));
    q.rec_sex     = 1'($urandom);
    q.name_first8 = {$urandom, $urandom};
    q.name_next8  = {$urandom, $urandom};
    q.name_last4  = $urandom;
    q.rec_year    = 14'($urandom_range(9999));
    return q;
  endfunction

  task automatic send_op(logic [2:0] op, logic [15:0] key);
    srt_pkg::req_t q;
    q = rand_req(op);
    q.rec_key = key;
    send_req(q);
  endtask

  initial begin
    int n, p;
    srt_pkg::req_t q;
    sb = new();
    calm = 1'b0;
    keyspan = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-table cases, extremes, head insert, duplicates, full.
    send_op(srt_pkg::REQ_SORT, 16'h0);
    send_op(srt_pkg::REQ_DELETE, 16'h5);
    send_op(srt_pkg::REQ_DUMP, 16'h0);
    q = '0; q.req_type = srt_pkg::REQ_APPEND; q.rec_key = 16'hFFFF; q.rec_sex = 1'b1;
    q.name_first8 = '1; q.name_next8 = '1; q.name_last4 = '1; q.rec_year = 14'd9999;
    send_req(q);
    q = '0; q.req_type = srt_pkg::REQ_APPEND;
    send_req(q);
    send_op(srt_pkg::REQ_INSERT, 16'h0);        // equal key goes first, at the head
    send_op(srt_pkg::REQ_INSERT, 16'h8000);
    send_op(srt_pkg::REQ_DELETE, 16'h1234);     // no match
    send_op(srt_pkg::REQ_SORT, 16'h0);
    send_op(srt_pkg::REQ_DUMP, 16'h0);
    send_op(3'd5, 16'h0);
    send_op(3'd7, 16'h0);
    send_op(srt_pkg::REQ_DELETE, 16'h0);        // removes first of equal keys
    for (int i = 0; i < 14; i++) send_op(srt_pkg::REQ_APPEND, 16'(15 - i));
    send_op(srt_pkg::REQ_APPEND, 16'h1);        // full
    send_op(srt_pkg::REQ_INSERT, 16'h1);        // full
    send_op(srt_pkg::REQ_DUMP, 16'h0);
    send_op(srt_pkg::REQ_SORT, 16'h0);
    send_op(srt_pkg::REQ_DUMP, 16'h0);

    // Random: fill/drain cycles with mixed operations, small key span at times.
    n = 0;
    while (n < 200) begin
      calm    = (n >= 80 && n < 120);
      keyspan = ($urandom_range(2) == 0) ? 7 : 0;
      p = $urandom_range(99);
      if (p < 25)      q = rand_req(srt_pkg::REQ_APPEND);
      else if (p < 45) q = rand_req(srt_pkg::REQ_INSERT);
      else if (p < 65) begin
        q = rand_req(srt_pkg::REQ_DELETE);
        if (sb.count > 0 && $urandom_range(3) != 0)
          q.rec_key = sb.rows[$urandom_range(sb.count - 1)].key;
      end
      else if (p < 78) q = rand_req(srt_pkg::REQ_SORT);
      else if (p < 95) q = rand_req(srt_pkg::REQ_DUMP);
      else             q = rand_req(3'($urandom_range(7, 5)));
      send_req(q);
      n++;
    end

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("sorted_record_table regression: pass");
    else
      $display("sorted_record_table regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("sorted_record_table regression: fail");
    $finish;
  end
endmodule

### sorted_record_table.f
hw/rtl/srt_pkg.sv
hw/rtl/srt_ram.sv
hw/rtl/srt_ctrl.sv
hw/rtl/srt_dpath.sv
hw/rtl/sorted_record_table.sv
hw/rtl/srt_checker.sv
dv/sorted_record_table_tb.sv
